[hdl/tic_pkg.sv]
// Shared types, constants and tables for the trigonometric interpolation core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tic_pkg;

    localparam int MAX_POINTS   = 64;
    localparam int PHASE_BITS   = 16;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int J_W          = 6;
    localparam int X_W          = 24;
    localparam int Y_W          = 32;
    localparam int COEF_W       = 48;
    localparam int MAG_W        = X_W + J_W;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int Z_W          = 34;
    localparam int XY_W         = 34;
    localparam int TRIG_W       = 32;
    localparam int PROD_W       = Y_W + TRIG_W;
    localparam int RND_W        = PROD_W - 30;
    localparam int ACC_W        = 40;
    localparam int DIV_W        = 42;
    localparam int DVSR_W       = CNT_W + 8;
    localparam int DIV_CNT_W    = $clog2(DIV_W);
    localparam int QF_W         = PHASE_BITS - 2;
    localparam int TWOPI_W      = 33;
    localparam int ZP_W         = QF_W + TWOPI_W;

    localparam logic [TWOPI_W-1:0] TWO_PI_Q30 = 33'd6746518852;
    localparam logic [XY_W-1:0]    CORDIC_X0  = 34'd652032874;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_CLEAR,
        OP_READ,
        OP_PROD,
        OP_MOD_GO,
        OP_PH_GO,
        OP_ANG,
        OP_ROT_GO,
        OP_MUL_C,
        OP_MUL_S,
        OP_ACC,
        OP_SCA_GO,
        OP_SCB_GO,
        OP_STORE_B
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [J_W-1:0]    j;
        logic [ADDR_W-1:0] idx;
        logic [CNT_W-1:0]  n;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rot_done;
    } dp_stat_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_START_J,
        ST_READ,
        ST_PROD,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_PH_GO,
        ST_PH_WAIT,
        ST_ANG,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_MUL_C,
        ST_MUL_S,
        ST_ACC,
        ST_SCA_GO,
        ST_SCA_WAIT,
        ST_SCB_GO,
        ST_SCB_WAIT,
        ST_STORE_B,
        ST_OUT
    } state_t;

    // Arctangent of 2^-i in Q.30 radians.
    function automatic logic [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] step);
        logic [Z_W-1:0] v;
        case (step)
            5'd0:    v = 34'd843314856;
            5'd1:    v = 34'd497837829;
            5'd2:    v = 34'd263043836;
            5'd3:    v = 34'd133525158;
            5'd4:    v = 34'd67021686;
            5'd5:    v = 34'd33543515;
            5'd6:    v = 34'd16775850;
            5'd7:    v = 34'd8388437;
            5'd8:    v = 34'd4194282;
            5'd9:    v = 34'd2097149;
            5'd10:   v = 34'd1048575;
            5'd11:   v = 34'd524287;
            5'd12:   v = 34'd262143;
            5'd13:   v = 34'd131071;
            5'd14:   v = 34'd65535;
            5'd15:   v = 34'd32767;
            5'd16:   v = 34'd16383;
            5'd17:   v = 34'd8191;
            5'd18:   v = 34'd4095;
            5'd19:   v = 34'd2047;
            5'd20:   v = 34'd1023;
            5'd21:   v = 34'd511;
            5'd22:   v = 34'd255;
            5'd23:   v = 34'd127;
            5'd24:   v = 34'd63;
            5'd25:   v = 34'd31;
            5'd26:   v = 34'd16;
            5'd27:   v = 34'd8;
            5'd28:   v = 34'd4;
            5'd29:   v = 34'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/tic_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tic_div
    import tic_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DVSR_W-1:0] divisor,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient,
    output logic [DVSR_W-1:0]      remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DVSR_W-1:0]    rem_reg;
    logic [DVSR_W-1:0]    dvsr_reg;
    logic [DVSR_W:0]      trial;
    logic [DVSR_W:0]      diff;
    logic                 ge;

    always_comb begin
        trial = {rem_reg, dsr_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        ge    = trial >= {1'b0, dvsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dsr_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
            dsr_reg <= {dsr_reg[DIV_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = dsr_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[hdl/tic_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with quadrant fold.
// Depends on tic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tic_cordic
    import tic_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [Z_W-1:0]    z_in,
    input  wire logic [1:0]               quad_in,
    output logic                          done,
    output logic signed [TRIG_W-1:0]      cos_out,
    output logic signed [TRIG_W-1:0]      sin_out
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_W-1:0]      step_reg;
    logic signed [XY_W-1:0] xc_reg;
    logic signed [XY_W-1:0] yc_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [1:0]             quad_reg;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;
    logic signed [XY_W-1:0] c_full;
    logic signed [XY_W-1:0] s_full;

    always_comb begin
        dx  = yc_reg >>> step_reg;
        dy  = xc_reg >>> step_reg;
        ang = $signed(atan_q30(step_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            xc_reg   <= $signed(CORDIC_X0);
            yc_reg   <= '0;
            z_reg    <= z_in;
            quad_reg <= quad_in;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                xc_reg <= xc_reg - dx;
                yc_reg <= yc_reg + dy;
                z_reg  <= z_reg - ang;
            end else begin
                xc_reg <= xc_reg + dx;
                yc_reg <= yc_reg - dy;
                z_reg  <= z_reg + ang;
            end
        end
    end

    // Fold the first-quadrant result out to the full circle.
    always_comb begin
        case (quad_reg)
            2'd0: begin
                c_full = xc_reg;
                s_full = yc_reg;
            end
            2'd1: begin
                c_full = -yc_reg;
                s_full = xc_reg;
            end
            2'd2: begin
                c_full = -xc_reg;
                s_full = -yc_reg;
            end
            default: begin
                c_full = yc_reg;
                s_full = -xc_reg;
            end
        endcase
    end

    assign done    = done_reg;
    assign cos_out = c_full[TRIG_W-1:0];
    assign sin_out = s_full[TRIG_W-1:0];

endmodule

`default_nettype wire

[hdl/tic_dp.sv]
// Datapath: point store, phase reduction, CORDIC, multiply-accumulate and scaling.
// Depends on tic_pkg, tic_div and tic_cordic.
`timescale 1ns / 1ps
`default_nettype none

module tic_dp
    import tic_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire dp_cmd_t                   cmd,
    output dp_stat_t                       stat,
    input  wire logic signed [X_W-1:0]     s_x_position,
    input  wire logic signed [Y_W-1:0]     s_y_value,
    output logic signed [COEF_W-1:0]       cos_coef,
    output logic signed [COEF_W-1:0]       sin_coef
);

    logic signed [X_W-1:0]    x_mem [MAX_POINTS];
    logic signed [Y_W-1:0]    y_mem [MAX_POINTS];
    logic signed [X_W-1:0]    x_rd_reg;
    logic signed [Y_W-1:0]    y_rd_reg;
    logic                     jx_neg_reg;
    logic [MAG_W-1:0]         jx_mag_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [1:0]               quad_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  sa_reg;
    logic signed [ACC_W-1:0]  sb_reg;
    logic                     sgn_reg;
    logic signed [COEF_W-1:0] coef_a_reg;
    logic signed [COEF_W-1:0] coef_b_reg;

    logic signed [MAG_W:0]    jx;
    logic [DVSR_W-1:0]        big_n;
    logic [DVSR_W-1:0]        r_mod;
    logic [PHASE_BITS-1:0]    phase;
    logic [ZP_W-1:0]          zp;
    logic signed [RND_W-1:0]  rnd;
    logic signed [ACC_W:0]    t_sum;
    logic [ACC_W:0]           t_mag;
    logic signed [COEF_W-1:0] qv;
    logic signed [COEF_W-1:0] q_signed;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DVSR_W-1:0]        div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quot;
    logic [DVSR_W-1:0]        div_rem;
    logic                     rot_done;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;

    always_comb begin
        jx    = $signed({1'b0, cmd.j}) * x_rd_reg;
        big_n = {cmd.n, 8'b0};
        // Fold a truncated negative remainder into [0, N).
        r_mod = (jx_neg_reg && div_rem != '0) ? big_n - div_rem : div_rem;
        phase = div_quot[PHASE_BITS-1:0];
        zp    = ZP_W'(phase[QF_W-1:0]) * ZP_W'(TWO_PI_Q30);
        rnd   = RND_W'((prod_reg + PROD_W'(64'sd536870912)) >>> 30);
        t_sum = (cmd.op == OP_SCA_GO) ? {sa_reg, 1'b0} : {sb_reg, 1'b0};
        t_mag = t_sum[ACC_W] ? ACC_W'(1) + ~t_sum : t_sum;
        qv       = COEF_W'(div_quot);
        q_signed = sgn_reg ? -qv : qv;
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = big_n;
        case (cmd.op)
            OP_MOD_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(jx_mag_reg);
            end
            OP_PH_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({r_mod, {PHASE_BITS{1'b0}}}) + DIV_W'(big_n >> 1);
            end
            OP_SCA_GO, OP_SCB_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(t_mag) + DIV_W'(cmd.n >> 1);
                div_divisor  = DVSR_W'(cmd.n);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE) begin
            x_mem[cmd.idx] <= s_x_position;
            y_mem[cmd.idx] <= s_y_value;
        end
        if (cmd.op == OP_READ) begin
            x_rd_reg <= x_mem[cmd.idx];
            y_rd_reg <= y_mem[cmd.idx];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CLEAR: begin
                sa_reg <= '0;
                sb_reg <= '0;
            end
            OP_PROD: begin
                jx_neg_reg <= jx[MAG_W];
                jx_mag_reg <= jx[MAG_W] ? MAG_W'(-jx) : jx[MAG_W-1:0];
            end
            OP_ANG: begin
                quad_reg <= phase[PHASE_BITS-1:PHASE_BITS-2];
                z_reg    <= $signed(Z_W'((zp + ZP_W'(1 << (PHASE_BITS - 1))) >> PHASE_BITS));
            end
            OP_MUL_C: begin
                prod_reg <= y_rd_reg * cos_val;
            end
            OP_MUL_S: begin
                sa_reg   <= sa_reg + ACC_W'(rnd);
                prod_reg <= y_rd_reg * sin_val;
            end
            OP_ACC: begin
                sb_reg <= sb_reg + ACC_W'(rnd);
            end
            OP_SCA_GO: begin
                sgn_reg <= sa_reg[ACC_W-1];
            end
            OP_SCB_GO: begin
                coef_a_reg <= q_signed;
                sgn_reg    <= sb_reg[ACC_W-1];
            end
            OP_STORE_B: begin
                coef_b_reg <= q_signed;
            end
            default: begin
                sgn_reg <= sgn_reg;
            end
        endcase
    end

    tic_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    tic_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_ROT_GO),
        .z_in    (z_reg),
        .quad_in (quad_reg),
        .done    (rot_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    assign stat.div_done = div_done;
    assign stat.rot_done = rot_done;
    assign cos_coef      = coef_a_reg;
    assign sin_coef      = coef_b_reg;

endmodule

`default_nettype wire

[hdl/tic_ctrl.sv]
// Controller: point counting, harmonic and point loops, handshakes.
// Depends on tic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tic_ctrl
    import tic_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_last_point,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [J_W-1:0]   harmonic,
    output logic             last_result,
    output logic             overflow,
    output dp_cmd_t          cmd,
    input  wire dp_stat_t    stat
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              dropped_reg, dropped_next;
    logic [J_W-1:0]    j_reg, j_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic              j_last;
    logic              i_last;

    assign j_last = j_reg == J_W'(cnt_reg >> 1);
    assign i_last = (CNT_W'(i_reg) + CNT_W'(1)) == cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            j_reg       <= '0;
            i_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
            j_reg       <= j_next;
            i_reg       <= i_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dropped_next = dropped_reg;
        j_next       = j_reg;
        i_next       = i_reg;
        cmd.op       = OP_NONE;
        cmd.j        = j_reg;
        cmd.idx      = i_reg;
        cmd.n        = cnt_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                cmd.idx = cnt_reg[ADDR_W-1:0];
                if (s_valid) begin
                    if (cnt_reg < CNT_W'(MAX_POINTS)) begin
                        cmd.op   = OP_WRITE;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last_point) begin
                        j_next     = '0;
                        state_next = ST_START_J;
                    end
                end
            end
            ST_START_J: begin
                cmd.op     = OP_CLEAR;
                i_next     = '0;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.op     = OP_READ;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.op     = OP_PROD;
                state_next = ST_MOD_GO;
            end
            ST_MOD_GO: begin
                cmd.op     = OP_MOD_GO;
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_PH_GO;
                end
            end
            ST_PH_GO: begin
                cmd.op     = OP_PH_GO;
                state_next = ST_PH_WAIT;
            end
            ST_PH_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_ANG;
                end
            end
            ST_ANG: begin
                cmd.op     = OP_ANG;
                state_next = ST_ROT_GO;
            end
            ST_ROT_GO: begin
                cmd.op     = OP_ROT_GO;
                state_next = ST_ROT_WAIT;
            end
            ST_ROT_WAIT: begin
                if (stat.rot_done) begin
                    state_next = ST_MUL_C;
                end
            end
            ST_MUL_C: begin
                cmd.op     = OP_MUL_C;
                state_next = ST_MUL_S;
            end
            ST_MUL_S: begin
                cmd.op     = OP_MUL_S;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op = OP_ACC;
                if (i_last) begin
                    state_next = ST_SCA_GO;
                end else begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_SCA_GO: begin
                cmd.op     = OP_SCA_GO;
                state_next = ST_SCA_WAIT;
            end
            ST_SCA_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_SCB_GO;
                end
            end
            ST_SCB_GO: begin
                cmd.op     = OP_SCB_GO;
                state_next = ST_SCB_WAIT;
            end
            ST_SCB_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_STORE_B;
                end
            end
            ST_STORE_B: begin
                cmd.op     = OP_STORE_B;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (j_last) begin
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end else begin
                        j_next     = j_reg + J_W'(1);
                        state_next = ST_START_J;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign harmonic    = j_reg;
    assign last_result = j_last;
    assign overflow    = dropped_reg;

endmodule

`default_nettype wire

[hdl/trig_interpolation_coefficients_core.sv]
// Trigonometric interpolation coefficients (real DFT of a point set).
// Loading accepts one word per cycle. After the closing word, each harmonic makes two
// divider passes and a 30-step CORDIC rotation per stored point, then scales both
// sums through the same divider; one item at a time.
// Reset (aresetn low, synchronous) empties the point count and the drop flag.
`timescale 1ns / 1ps
`default_nettype none

module trig_interpolation_coefficients_core
    import tic_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Point input channel.
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [X_W-1:0]    s_x_position,
    input  wire logic signed [Y_W-1:0]    s_y_value,
    input  wire logic                     s_last_point,
    // Coefficient output channel.
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [J_W-1:0]                m_harmonic_index,
    output logic signed [COEF_W-1:0]      m_cos_coefficient,
    output logic signed [COEF_W-1:0]      m_sin_coefficient,
    output logic                          m_last_result,
    output logic                          m_overflow_flag
);

    // The controller walks harmonics j = 0..n/2 and, inside each, the stored points.
    // For each point the datapath reduces j*x modulo n*256, converts the remainder to a
    // phase in turns, rotates through the CORDIC and accumulates y*cos and y*sin.
    // The sums stay far inside 48 bits (at most 2^38 in magnitude), so the scaled
    // coefficients never clip and the overflow flag reports dropped points alone.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    tic_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_point (s_last_point),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .harmonic     (m_harmonic_index),
        .last_result  (m_last_result),
        .overflow     (m_overflow_flag),
        .cmd          (cmd),
        .stat         (stat)
    );

    // Hold finished coefficients in registers until the word is taken.
    tic_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_x_position (s_x_position),
        .s_y_value    (s_y_value),
        .cos_coef     (m_cos_coefficient),
        .sin_coef     (m_sin_coefficient)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for trig_interpolation_coefficients_core.
// It predicts each point set's coefficients, checks every output word in order and
// randomizes stalls on both channels. It depends on tic_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
    import tic_pkg::*;

    // Expected coefficient word for one harmonic.
    typedef struct {
        logic [J_W-1:0]           j;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic                     last;
        logic                     ovf;
    } coef_word_t;

    // Arctangent of 2^-i, Q.30 radians, used by the rotation loop below.
    localparam longint ATAN_TAB [CORDIC_STEPS] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 16, 8, 4, 2
    };
    localparam longint COEF_HI = 64'sd140737488355327;
    localparam longint COEF_LO = -64'sd140737488355328;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [X_W-1:0] s_x_position = '0;
    logic signed [Y_W-1:0] s_y_value = '0;
    logic s_last_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [J_W-1:0] m_harmonic_index;
    logic signed [COEF_W-1:0] m_cos_coefficient;
    logic signed [COEF_W-1:0] m_sin_coefficient;
    logic m_last_result;
    logic m_overflow_flag;

    trig_interpolation_coefficients_core dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_x_position      (s_x_position),
        .s_y_value         (s_y_value),
        .s_last_point      (s_last_point),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_harmonic_index  (m_harmonic_index),
        .m_cos_coefficient (m_cos_coefficient),
        .m_sin_coefficient (m_sin_coefficient),
        .m_last_result     (m_last_result),
        .m_overflow_flag   (m_overflow_flag)
    );

    always #5 aclk = ~aclk;

    // Predictor state: the points of the open set and the drop flag.
    longint     pts_x [$];
    longint     pts_y [$];
    bit         pts_dropped = 1'b0;
    coef_word_t coef_pending [$];

    int  mismatches = 0;
    bit  stalls_on = 1'b1;   // random idling on both sides
    int  hold_left = 0;      // long receiver hold-off, in cycles
    int  stall_left = 0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!stalls_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Rotation-mode CORDIC on a PHASE_BITS phase in turns; returns Q.30 cos and sin.
    function automatic void rotate_phase(input longint ph, output longint c,
                                         output longint s);
        longint z, xc, yc, dx, dy, q;
        int quad;
        quad = int'((ph >> (PHASE_BITS - 2)) & 3);
        q    = ph & ((64'sd1 << (PHASE_BITS - 2)) - 1);
        z    = (q * 64'sd6746518852 + (64'sd1 << (PHASE_BITS - 1))) >>> PHASE_BITS;
        xc   = 64'sd652032874;
        yc   = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = yc >>> i;
            dy = xc >>> i;
            if (z >= 0) begin
                xc -= dx; yc += dy; z -= ATAN_TAB[i];
            end else begin
                xc += dx; yc -= dy; z += ATAN_TAB[i];
            end
        end
        case (quad)
            0: begin c = xc;  s = yc;  end
            1: begin c = -yc; s = xc;  end
            2: begin c = -xc; s = -yc; end
            default: begin c = yc; s = -xc; end
        endcase
    endfunction

    // 2*sum/n, rounded half away from zero, then clipped to 48 bits.
    function automatic longint scale_sum(input longint sum, input longint n, inout bit sat);
        longint t, r;
        t = 2 * sum;
        if (t >= 0) r = (t + n / 2) / n;
        else        r = -((-t + n / 2) / n);
        if (r > COEF_HI) begin sat = 1'b1; return COEF_HI; end
        if (r < COEF_LO) begin sat = 1'b1; return COEF_LO; end
        return r;
    endfunction

    // Take one accepted point; on the closing point, queue every harmonic of the set.
    function automatic void absorb_point(input logic signed [X_W-1:0] x,
                                         input logic signed [Y_W-1:0] y, input logic last);
        coef_word_t words [$];
        coef_word_t w;
        longint n, big_n, r, ph, c, s, sa, sb;
        int m;
        bit sat;
        sat = 1'b0;
        if (pts_x.size() < MAX_POINTS) begin
            pts_x.push_back(longint'(x));
            pts_y.push_back(longint'(y));
        end else begin
            pts_dropped = 1'b1;
        end
        if (!last) return;
        n     = pts_x.size();
        big_n = n * 256;
        m     = int'(n / 2);
        for (int j = 0; j <= m; j++) begin
            sa = 0;
            sb = 0;
            for (int i = 0; i < n; i++) begin
                r = (longint'(j) * pts_x[i]) % big_n;
                if (r < 0) r += big_n;
                ph = (((r << PHASE_BITS) + big_n / 2) / big_n) & ((64'sd1 << PHASE_BITS) - 1);
                rotate_phase(ph, c, s);
                sa += (pts_y[i] * c + (64'sd1 << 29)) >>> 30;
                sb += (pts_y[i] * s + (64'sd1 << 29)) >>> 30;
            end
            w.j    = J_W'(j);
            w.a    = COEF_W'(scale_sum(sa, n, sat));
            w.b    = COEF_W'(scale_sum(sb, n, sat));
            w.last = (j == m);
            w.ovf  = 1'b0;
            words.push_back(w);
        end
        foreach (words[k]) begin
            words[k].ovf = sat || pts_dropped;
            coef_pending.push_back(words[k]);
        end
        pts_x.delete();
        pts_y.delete();
        pts_dropped = 1'b0;
    endfunction

    // Offer one word after an optional gap; hold it until accepted. Entered at a rising edge.
    task automatic send_point(input logic signed [X_W-1:0] x, input logic signed [Y_W-1:0] y,
                              input logic last);
        int  gap;
        bit  rdy;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_x_position <= x;
        s_y_value    <= y;
        s_last_point <= last;
        // Sample ready mid-cycle; nothing changes it before the next rising edge.
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        absorb_point(x, y, last);
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_point($signed(X_W'($urandom)), $signed($urandom), i == n - 1);
    endtask

    // Single point: n = 1 yields only harmonic zero.
    task automatic test_single_point();
        send_point('0, 32'sh7FFF_FFFF, 1'b1);
        send_point(24'sh7F_FFFF, 32'sh8000_0000, 1'b1);
    endtask

    // Extremes of both fields, with small sets of four, two and three points.
    task automatic test_field_extremes();
        send_point(24'sh7F_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_point(24'sh80_0000, 32'sh8000_0000, 1'b0);
        send_point(24'sh00_0100, 32'sh0001_0000, 1'b0);
        send_point(-24'sh00_0100, -32'sh0001_0000, 1'b1);
        send_point(24'sh00_0080, 32'sh7FFF_FFFF, 1'b0);
        send_point(24'shFF_FFFF, 32'shFFFF_FFFF, 1'b1);
        send_point(24'sh80_0000, 32'sh7FFF_FFFF, 1'b0);
        send_point(24'sh00_0001, 32'sh8000_0000, 1'b0);
        send_point(24'sh7F_FFFF, 32'sh0000_0000, 1'b1);
    endtask

    // Fill the store, then send one more closing point that gets dropped.
    task automatic test_store_full();
        for (int i = 0; i < MAX_POINTS; i++)
            send_point($signed(24'(i * 256 + $urandom_range(0, 255))), $signed($urandom), 1'b0);
        send_point(24'sh12_3456, 32'sh1234_5678, 1'b1);
    endtask

    // Hold the result side off for a long stretch while sets keep coming.
    task automatic test_output_hold();
        stalls_on = 1'b0;
        hold_left = 3000;
        for (int k = 0; k < 5; k++) send_set($urandom_range(1, 3));
        stalls_on = 1'b1;
    endtask

    // Random sets, mostly small, now and then larger; a few stretches without idling.
    task automatic test_random_sets();
        int sent;
        int n;
        sent = 0;
        while (sent < 330) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
            stalls_on = ($urandom_range(0, 4) != 0);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 1))
                    send_point($signed(X_W'($urandom)), $signed($urandom), i == n - 1);
                else
                    send_point($signed(24'($urandom_range(0, n * 256 - 1)) - 24'(n * 128)),
                               $signed($urandom), i == n - 1);
            end
            sent += n;
        end
        stalls_on = 1'b1;
    endtask

    // Result side: long hold-off first, then random stalls.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
            end
            @(posedge aclk);
        end
    end

    // Check each accepted word against the oldest expectation; sampled mid-cycle.
    always @(negedge aclk) begin
        coef_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (coef_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: j=%0d a=%0d b=%0d", m_harmonic_index,
                             m_cos_coefficient, m_sin_coefficient);
            end else begin
                e = coef_pending.pop_front();
                if (m_harmonic_index !== e.j || m_cos_coefficient !== e.a ||
                    m_sin_coefficient !== e.b || m_last_result !== e.last ||
                    m_overflow_flag !== e.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp j=%0d a=%0d b=%0d last=%b ovf=%b / got j=%0d a=%0d b=%0d last=%b ovf=%b",
                                 e.j, e.a, e.b, e.last, e.ovf, m_harmonic_index,
                                 m_cos_coefficient, m_sin_coefficient, m_last_result,
                                 m_overflow_flag);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_point();
        test_field_extremes();
        test_store_full();
        test_output_hold();
        test_random_sets();
        s_valid <= 1'b0;
        // Drain, then let the core settle.
        while (coef_pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && coef_pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout well past the slowest legal run.
    initial begin
        #(80_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
hdl/tic_pkg.sv
hdl/tic_div.sv
hdl/tic_cordic.sv
hdl/tic_dp.sv
hdl/tic_ctrl.sv
hdl/trig_interpolation_coefficients_core.sv
test/tb_top.sv
